[design/ufw_pkg.sv]
// ----------------------------------------------------------------------------
// ufw_pkg
// Shared constants, microcode types and the control store of the weighted
// union-find engine.
// ----------------------------------------------------------------------------
package ufw_pkg;

  localparam int NODES  = 1024;
  localparam int IDX_W  = $clog2(NODES);
  localparam int SIZE_W = $clog2(NODES) + 1;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_RDA   = 4'd1;
  localparam step_t S_WALKA = 4'd2;
  localparam step_t S_LINKA = 4'd3;
  localparam step_t S_WALKB = 4'd4;
  localparam step_t S_LINKB = 4'd5;
  localparam step_t S_RDSZ  = 4'd6;
  localparam step_t S_MERGE = 4'd7;
  localparam step_t S_CLR   = 4'd8;

  typedef enum logic [2:0] {
    A_IDLE,
    A_READ,
    A_WALK,
    A_LINKA,
    A_LINKB,
    A_RDSZ,
    A_MERGE,
    A_CLEAR
  } act_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_START,
    C_ROOT,
    C_SKIP,
    C_LAST
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t jmp;   // taken when cond holds
    step_t nxt;   // taken otherwise
  } uword_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    unique case (s)
      S_IDLE:  w = '{A_IDLE,  C_START,  S_RDA,   S_IDLE};
      S_RDA:   w = '{A_READ,  C_ALWAYS, S_WALKA, S_WALKA};
      S_WALKA: w = '{A_WALK,  C_ROOT,   S_LINKA, S_WALKA};
      S_LINKA: w = '{A_LINKA, C_ALWAYS, S_WALKB, S_WALKB};
      S_WALKB: w = '{A_WALK,  C_ROOT,   S_LINKB, S_WALKB};
      S_LINKB: w = '{A_LINKB, C_SKIP,   S_IDLE,  S_RDSZ};
      S_RDSZ:  w = '{A_RDSZ,  C_ALWAYS, S_MERGE, S_MERGE};
      S_MERGE: w = '{A_MERGE, C_ALWAYS, S_IDLE,  S_IDLE};
      S_CLR:   w = '{A_CLEAR, C_LAST,   S_IDLE,  S_CLR};
      default: w = '{A_IDLE,  C_ALWAYS, S_IDLE,  S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[design/ufw_ram.sv]
// ----------------------------------------------------------------------------
// ufw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module ufw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/union_find_weighted.sv]
// ----------------------------------------------------------------------------
// union_find_weighted
// Disjoint-set engine: weighted union with one-step path compression, run by
// a microcoded sequencer over a parent RAM and a tree-size RAM.
// ----------------------------------------------------------------------------
// Sequence: after the accepting edge the engine reads node a, walks its parent
// links to the root (one link walked per cycle through the parent RAM read
// port), links a to that root, walks b the same way, links b to its root and
// registers the result strobe. A union that merges holds busy longer for the
// size read and the merge write; busy blocks new items. The receiver cannot stall.
// Reset: a clearing pass over all NODES entries rewrites both RAMs, busy high.
module union_find_weighted
  import ufw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_operation,
  input  logic [9:0] in_node_a,
  input  logic [9:0] in_node_b,
  output logic       out_valid,
  output logic       out_connected
);

  step_t              step_r, step_nxt;
  uword_t             uw;
  logic               cond_hit;
  logic               root;
  logic               accept;

  logic               op_r;
  logic [IDX_W-1:0]   a_r, b_r, cur_r, ra_r;
  logic [SIZE_W-1:0]  sa_r;
  logic               out_valid_r, out_connected_r;

  logic               p_we;
  logic [IDX_W-1:0]   p_waddr, p_wdata, p_raddr, p_rdata;
  logic               s_we;
  logic [IDX_W-1:0]   s_waddr, s_raddr;
  logic [SIZE_W-1:0]  s_wdata, s_rdata;

  ufw_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_parent (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  ufw_ram #(.WIDTH(SIZE_W), .DEPTH(NODES)) u_size (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign uw     = ucode(step_r);
  assign busy   = (step_r != S_IDLE);
  assign accept = start && !busy;
  assign root   = (p_rdata == cur_r);

  always_comb begin
    case (uw.cond)
      C_ALWAYS: cond_hit = 1'b1;
      C_START:  cond_hit = start;
      C_ROOT:   cond_hit = root;
      C_SKIP:   cond_hit = op_r || (ra_r == cur_r);
      C_LAST:   cond_hit = (cur_r == IDX_W'(NODES - 1));
      default:  cond_hit = 1'b1;
    endcase
    step_nxt = cond_hit ? uw.jmp : uw.nxt;
  end

  // RAM port control per microcode action
  always_comb begin
    p_we    = 1'b0;
    p_waddr = cur_r;
    p_wdata = cur_r;
    p_raddr = cur_r;
    s_we    = 1'b0;
    s_waddr = cur_r;
    s_wdata = SIZE_W'(1);
    s_raddr = ra_r;
    unique case (uw.act)
      A_IDLE: begin
      end
      A_READ: begin
        p_raddr = cur_r;
      end
      A_WALK: begin
        p_raddr = p_rdata;
      end
      A_LINKA: begin
        p_we    = 1'b1;
        p_waddr = a_r;
        p_wdata = cur_r;
        p_raddr = b_r;
      end
      A_LINKB: begin
        p_we    = 1'b1;
        p_waddr = b_r;
        p_wdata = cur_r;
        s_raddr = ra_r;
      end
      A_RDSZ: begin
        s_raddr = cur_r;
      end
      A_MERGE: begin
        p_we    = 1'b1;
        s_we    = 1'b1;
        s_wdata = sa_r + s_rdata;
        // smaller tree goes under the larger; a tie keeps the first root on top
        if (sa_r < s_rdata) begin
          p_waddr = ra_r;
          p_wdata = cur_r;
          s_waddr = cur_r;
        end else begin
          p_waddr = cur_r;
          p_wdata = ra_r;
          s_waddr = ra_r;
        end
      end
      A_CLEAR: begin
        p_we = 1'b1;
        s_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_CLR;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= (uw.act == A_LINKB);
      if (uw.act == A_LINKB) begin
        out_connected_r <= (ra_r == cur_r);
      end
      case (uw.act)
        A_IDLE: begin
          if (accept) begin
            op_r  <= in_operation;
            a_r   <= IDX_W'(32'(in_node_a) % NODES);
            b_r   <= IDX_W'(32'(in_node_b) % NODES);
            cur_r <= IDX_W'(32'(in_node_a) % NODES);
          end
        end
        A_WALK: begin
          if (!root) begin
            cur_r <= p_rdata;
          end
        end
        A_LINKA: begin
          ra_r  <= cur_r;
          cur_r <= b_r;
        end
        A_RDSZ: begin
          sa_r <= s_rdata;
        end
        A_CLEAR: begin
          cur_r <= cur_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_connected = out_connected_r;

  // a result beat only follows a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without work in progress");

  // an accepted item is never answered on the next cycle
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (!out_valid && busy))
    else $error("accept not followed by busy work");

  // one result beat per item
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat repeated");

endmodule
